// File: rtl/gwf_pkg.sv
// ----------------------------------------------------------------------------
// gwf_pkg: glob wildcard filter shared definitions
// Widths, special bytes, register indexes, item types and the star closure.
// ----------------------------------------------------------------------------
package gwf_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int MATCH_CAP   = 32;
  localparam int POS_W       = PATTERN_MAX + 1;
  localparam int LEN_W       = 6;
  localparam int CNT_W       = 6;
  localparam int IDX_W       = 5;
  localparam int NUM_WORDS   = 4;
  localparam int WORD_W      = 64;
  localparam int PAT_BITS    = NUM_WORDS * WORD_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;
  localparam logic [7:0] CH_DOT  = 8'h2E;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_WORD0   = 3'd0,
    REG_PAT_WORD1   = 3'd1,
    REG_PAT_WORD2   = 3'd2,
    REG_PAT_WORD3   = 3'd3,
    REG_PAT_LENGTH  = 3'd4,
    REG_MATCH_LIMIT = 3'd5
  } cfg_reg_t;

  typedef logic [POS_W-1:0] pos_set_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       first_byte;
    logic       last_byte;
    logic       empty_name;
    logic       new_scan;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic             pattern_matched;
    logic             hidden_dot;
    logic             cap_reached;
    logic [IDX_W-1:0] match_index;
  } out_item_t;

  // A set bit on a star of a run reaches every later position up to
  // one past the run; the carry chain of one add does the propagation.
  function automatic pos_set_t star_closure(pos_set_t set, pos_set_t star);
    pos_set_t t;
    t = set & star;
    return set | ((star + t) ^ star ^ t);
  endfunction

endpackage

// File: rtl/gwf_if.sv
// ----------------------------------------------------------------------------
// gwf_if: glob wildcard filter channel interfaces
// Valid/ready channels for name-byte requests and verdict results.
// ----------------------------------------------------------------------------
interface gwf_in_if;
  import gwf_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gwf_out_if;
  import gwf_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/glob_wildcard_filter.sv
// ----------------------------------------------------------------------------
// glob_wildcard_filter: glob pattern filter for directory-entry names
//
// Name bytes come in one per request on in_req; a request with last_byte or
// empty_name set produces one verdict on out_res, other requests produce none.
// The pattern ('*', '?', literal bytes), its length and the name limit are
// written through the cfg_ write port while no name is in flight.
// A request taken at a clock edge sits in the input register and its verdict
// is loaded into the output register once that register can take it. One
// request per cycle is sustained while out_res.ready is high; the
// active-position update (32 parallel position compares and two chained
// 33-bit adds for star runs) is combinational. A stalled result holds in the
// output register while one more request is taken into the input register; then in_req.ready drops.
// Reset clears both registers, sets the pattern to empty, the limit to 32,
// the accepted-name counter to zero and the matcher to its start positions.
// ----------------------------------------------------------------------------
module glob_wildcard_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [gwf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gwf_pkg::CFG_DATA_W-1:0] cfg_data,
  gwf_in_if.sink                         in_req,
  gwf_out_if.source                      out_res
);
  import gwf_pkg::*;

  logic [WORD_W-1:0] pat_word_r [NUM_WORDS];
  logic [LEN_W-1:0]  pat_length_r;
  logic [CNT_W-1:0]  match_limit_r;

  logic              in_valid_r;
  in_item_t          item_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  pos_set_t          active_r;
  logic              at_start_r;
  logic              leading_dot_r;
  logic [CNT_W-1:0]  count_r;

  logic [PAT_BITS-1:0] pat_bits;
  logic [LEN_W-1:0]    pat_len;
  logic [CNT_W-1:0]    limit;
  pos_set_t            star_mask;
  pos_set_t            step_mask;
  pos_set_t            start_set;
  pos_set_t            base_set;
  pos_set_t            adv_set;
  pos_set_t            fin_set;
  logic                move_w;
  logic                proc_w;
  logic                verdict;
  logic                dot_now;
  logic                matched;
  logic                pat_dot;
  logic                hidden;
  logic                cap;
  logic                acc;
  logic [CNT_W-1:0]    cnt_base;
  logic [CNT_W-1:0]    cnt_inc;
  logic                cfg_hit;

  assign pat_bits = {pat_word_r[3], pat_word_r[2], pat_word_r[1], pat_word_r[0]};
  assign pat_len  = (pat_length_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                         : pat_length_r;
  assign limit    = (match_limit_r > CNT_W'(MATCH_CAP)) ? CNT_W'(MATCH_CAP)
                                                        : match_limit_r;

  always_comb begin
    star_mask = '0;
    step_mask = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LEN_W'(i) < pat_len) begin
        star_mask[i] = (pat_bits[8*i +: 8] == CH_STAR);
        step_mask[i] = (pat_bits[8*i +: 8] == CH_ANY) ||
                       (pat_bits[8*i +: 8] == item_r.name_byte);
      end
    end
  end

  assign start_set = star_closure(pos_set_t'(1), star_mask);
  assign base_set  = (item_r.first_byte || at_start_r) ? start_set : active_r;
  assign adv_set   = star_closure((base_set & star_mask) |
                                  {base_set[POS_W-2:0] & step_mask[POS_W-2:0], 1'b0},
                                  star_mask);
  assign fin_set   = item_r.empty_name ? start_set : adv_set;

  assign verdict  = item_r.empty_name || item_r.last_byte;
  assign dot_now  = item_r.empty_name ? 1'b0 :
                    item_r.first_byte ? (item_r.name_byte == CH_DOT) : leading_dot_r;
  assign matched  = fin_set[pat_len];
  assign pat_dot  = (pat_len != '0) && (pat_bits[7:0] == CH_DOT);
  assign hidden   = matched && dot_now && !pat_dot;
  assign cnt_base = item_r.new_scan ? '0 : count_r;
  assign cnt_inc  = cnt_base + CNT_W'(1);
  assign cap      = (cnt_base >= limit);
  assign acc      = matched && !hidden && !cap;

  assign move_w       = !out_valid_r || out_res.ready;
  assign proc_w       = in_valid_r && move_w;
  assign in_req.ready = !in_valid_r || move_w;
  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

  assign cfg_hit = cfg_wr_en && (cfg_index <= REG_MATCH_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        pat_word_r[w] <= '0;
      end
      pat_length_r  <= '0;
      match_limit_r <= CNT_W'(MATCH_CAP);
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      at_start_r    <= 1'b1;
      leading_dot_r <= 1'b0;
      count_r       <= '0;
    end else begin
      if (in_req.ready) begin
        in_valid_r <= in_req.valid;
      end
      if (in_req.valid && in_req.ready) begin
        item_r <= in_req.data;
      end

      if (move_w) begin
        out_valid_r <= proc_w && verdict;
      end

      if (proc_w) begin
        count_r <= (verdict && acc) ? cnt_inc : cnt_base;
        if (verdict) begin
          at_start_r    <= 1'b1;
          leading_dot_r <= 1'b0;
          out_data_r.accepted        <= acc;
          out_data_r.pattern_matched <= matched;
          out_data_r.hidden_dot      <= hidden;
          out_data_r.cap_reached     <= cap;
          out_data_r.match_index     <= acc ? cnt_base[IDX_W-1:0] : '0;
        end else begin
          active_r      <= adv_set;
          at_start_r    <= 1'b0;
          leading_dot_r <= dot_now;
        end
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PAT_WORD0:   pat_word_r[0] <= cfg_data;
          REG_PAT_WORD1:   pat_word_r[1] <= cfg_data;
          REG_PAT_WORD2:   pat_word_r[2] <= cfg_data;
          REG_PAT_WORD3:   pat_word_r[3] <= cfg_data;
          REG_PAT_LENGTH:  pat_length_r  <= cfg_data[LEN_W-1:0];
          REG_MATCH_LIMIT: match_limit_r <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      // idle set follows the pattern in force
      if (cfg_hit) begin
        at_start_r <= 1'b1;
      end
    end
  end

  a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.accepted |->
      out_data_r.pattern_matched && !out_data_r.hidden_dot && !out_data_r.cap_reached)
    else $error("accepted verdict with a refusing flag");

  a_hidden_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.hidden_dot |-> out_data_r.pattern_matched)
    else $error("hidden flag on a name that did not match");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MATCH_CAP))
    else $error("accepted-name counter above cap");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    proc_w && verdict && acc |=> count_r == $past(cnt_inc))
    else $error("counter did not advance on accepted name");

endmodule

// File: sim/glob_wildcard_filter_tb.sv
// ----------------------------------------------------------------------------
// glob_wildcard_filter_tb: self-checking bench for the glob wildcard filter
// Feeds directory-entry names byte by byte, predicts each verdict from the
// pattern in force, and checks every result field in order. A short directed
// run covers the corner cases; random patterns and names follow, with idle
// and stall on both channels, a long result stall and a full drain pause.
// ----------------------------------------------------------------------------
import gwf_pkg::*;

class verdict_scoreboard;
  logic [63:0] pat_word [NUM_WORDS];
  logic [5:0]  pat_len_reg;
  logic [5:0]  limit_reg;
  pos_set_t    live_pos;
  bit          dot_seen;
  logic [5:0]  name_count;
  out_item_t   verdict_q [$];
  int          fails;
  int          shown;

  function new();
    foreach (pat_word[i]) pat_word[i] = '0;
    pat_len_reg = '0;
    limit_reg   = 6'd32;
    live_pos    = start_pos();
    dot_seen    = 1'b0;
    name_count  = '0;
    fails       = 0;
    shown       = 0;
  endfunction

  function int eff_len();
    return (pat_len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_reg);
  endfunction

  function logic [7:0] pat_char(int i);
    return pat_word[i / 8][(i % 8) * 8 +: 8];
  endfunction

  // a live star may be skipped, so the position after it is live too
  function pos_set_t spread_stars(pos_set_t s);
    for (int i = 0; i < eff_len(); i++)
      if (s[i] && pat_char(i) == CH_STAR) s[i + 1] = 1'b1;
    return s;
  endfunction

  function pos_set_t start_pos();
    return spread_stars(pos_set_t'(1));
  endfunction

  function pos_set_t step_pos(pos_set_t s, logic [7:0] c);
    pos_set_t nxt;
    nxt = '0;
    for (int i = 0; i < eff_len(); i++) begin
      if (s[i]) begin
        if (pat_char(i) == CH_STAR) nxt[i] = 1'b1;
        else if (pat_char(i) == CH_ANY || pat_char(i) == c) nxt[i + 1] = 1'b1;
      end
    end
    return spread_stars(nxt);
  endfunction

  function void configure(cfg_reg_t idx, logic [63:0] v);
    case (idx)
      REG_PAT_WORD0:   pat_word[0] = v;
      REG_PAT_WORD1:   pat_word[1] = v;
      REG_PAT_WORD2:   pat_word[2] = v;
      REG_PAT_WORD3:   pat_word[3] = v;
      REG_PAT_LENGTH:  pat_len_reg = v[5:0];
      REG_MATCH_LIMIT: limit_reg = v[5:0];
      default: return;
    endcase
    live_pos = start_pos();
  endfunction

  function int pending();
    return verdict_q.size();
  endfunction

  function void note(in_item_t it);
    pos_set_t  s;
    out_item_t v;
    int        lim;
    bit        lead_dot;
    if (it.new_scan) name_count = '0;
    if (it.empty_name) begin
      s = start_pos();
      dot_seen = 1'b0;
    end else begin
      s = it.first_byte ? start_pos() : live_pos;
      if (it.first_byte) dot_seen = (it.name_byte == CH_DOT);
      s = step_pos(s, it.name_byte);
      if (!it.last_byte) begin
        live_pos = s;
        return;
      end
    end
    lim = (limit_reg > MATCH_CAP) ? MATCH_CAP : int'(limit_reg);
    lead_dot = eff_len() > 0 && pat_char(0) == CH_DOT;
    v.pattern_matched = s[eff_len()];
    v.hidden_dot      = v.pattern_matched && dot_seen && !lead_dot;
    v.cap_reached     = name_count >= lim;
    v.accepted        = v.pattern_matched && !v.hidden_dot && !v.cap_reached;
    v.match_index     = v.accepted ? name_count[IDX_W-1:0] : '0;
    if (v.accepted) name_count = name_count + 6'd1;
    live_pos = start_pos();
    dot_seen = 1'b0;
    verdict_q.push_back(v);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    if (shown < 40) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      shown++;
    end
    fails++;
  endtask

  task check(out_item_t got);
    out_item_t want;
    if (verdict_q.size() == 0) begin
      report("verdict with none expected", 1, 0);
      return;
    end
    want = verdict_q.pop_front();
    if (got.accepted !== want.accepted)
      report("accepted", got.accepted, want.accepted);
    if (got.pattern_matched !== want.pattern_matched)
      report("pattern_matched", got.pattern_matched, want.pattern_matched);
    if (got.hidden_dot !== want.hidden_dot)
      report("hidden_dot", got.hidden_dot, want.hidden_dot);
    if (got.cap_reached !== want.cap_reached)
      report("cap_reached", got.cap_reached, want.cap_reached);
    if (got.match_index !== want.match_index)
      report("match_index", got.match_index, want.match_index);
  endtask
endclass

module glob_wildcard_filter_tb;
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gwf_in_if  in_if ();
  gwf_out_if out_if ();

  glob_wildcard_filter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_if),
    .out_res   (out_if)
  );

  verdict_scoreboard sb;
  in_item_t          stim_q [$];
  logic [7:0]        pat_bytes [PATTERN_MAX];
  int                pat_len_set;
  int                send_idle_pct;
  int                recv_idle_pct;
  bit                hold_req;
  int                hold_left;

  always #6 clk = ~clk;

  // result side: random ready, or a long hold when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 80;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note(in_if.data);
      if (out_if.valid && out_if.ready) sb.check(out_if.data);
    end
  end

  function automatic logic [7:0] alpha_byte();
    int r;
    r = $urandom_range(15);
    if (r < 6) return "a";
    if (r < 9) return "b";
    if (r == 9) return "c";
    if (r == 10) return CH_DOT;
    if (r == 11) return CH_STAR;
    if (r == 12) return CH_ANY;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_pat_byte();
    int r;
    r = $urandom_range(19);
    if (r < 5) return CH_STAR;
    if (r < 8) return CH_ANY;
    if (r == 8) return CH_DOT;
    if (r < 17) return (r % 3 == 0) ? "a" : (r % 3 == 1) ? "b" : "c";
    return 8'($urandom);
  endfunction

  function automatic logic [63:0] pack_word(int wi);
    logic [63:0] w;
    for (int b = 0; b < 8; b++) w[b * 8 +: 8] = pat_bytes[wi * 8 + b];
    return w;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [63:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.configure(idx, v);
    @(negedge clk);
  endtask

  // upper data bits are don't-care for the 6-bit registers
  task automatic apply_config(int len, int lim);
    logic [63:0] junk;
    write_reg(REG_PAT_WORD0, pack_word(0));
    write_reg(REG_PAT_WORD1, pack_word(1));
    write_reg(REG_PAT_WORD2, pack_word(2));
    write_reg(REG_PAT_WORD3, pack_word(3));
    junk = $urandom_range(1) ? {$urandom, $urandom} : '0;
    write_reg(REG_PAT_LENGTH, {junk[63:6], 6'(len)});
    junk = $urandom_range(1) ? {$urandom, $urandom} : '0;
    write_reg(REG_MATCH_LIMIT, {junk[63:6], 6'(lim)});
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    pat_len_set = len;
  endtask

  task automatic add_byte(logic [7:0] c, bit f, bit l, bit scan);
    in_item_t it;
    it.name_byte  = c;
    it.first_byte = f;
    it.last_byte  = l;
    it.empty_name = 1'b0;
    it.new_scan   = scan;
    stim_q.push_back(it);
  endtask

  // name_byte and the marks are ignored on an empty name
  task automatic add_empty(bit scan);
    in_item_t it;
    it.name_byte  = 8'($urandom);
    it.first_byte = 1'($urandom);
    it.last_byte  = 1'($urandom);
    it.empty_name = 1'b1;
    it.new_scan   = scan;
    stim_q.push_back(it);
  endtask

  task automatic add_text(string s, bit scan);
    for (int i = 0; i < s.len(); i++)
      add_byte(s[i], i == 0, i == s.len() - 1, scan && i == 0);
  endtask

  task automatic add_random_name();
    logic [7:0] nm [$];
    int         kind, eff, noise, scan_at, cut;
    bit         f, l;
    kind = $urandom_range(99);
    eff = (pat_len_set > PATTERN_MAX) ? PATTERN_MAX : pat_len_set;
    if (kind < 8) begin
      add_empty($urandom_range(9) == 0);
      return;
    end
    if (kind < 70) begin
      // built to fit the pattern, sometimes behind a dot or with one byte spoiled
      if ($urandom_range(4) == 0) nm.push_back(CH_DOT);
      for (int i = 0; i < eff; i++) begin
        if (pat_bytes[i] == CH_STAR) repeat ($urandom_range(2)) nm.push_back(alpha_byte());
        else if (pat_bytes[i] == CH_ANY) nm.push_back(alpha_byte());
        else nm.push_back(pat_bytes[i]);
      end
      if ($urandom_range(4) == 0 && nm.size() > 0)
        nm[$urandom_range(nm.size() - 1)] = alpha_byte();
    end else begin
      repeat ($urandom_range(1, 6)) nm.push_back(alpha_byte());
    end
    if (nm.size() == 0) begin
      add_empty($urandom_range(9) == 0);
      return;
    end
    noise = $urandom_range(99);
    scan_at = ($urandom_range(9) == 0) ? $urandom_range(nm.size() - 1) : -1;
    cut = (noise >= 5 && noise < 8 && nm.size() > 1) ? $urandom_range(1, nm.size() - 1) : -1;
    for (int i = 0; i < nm.size(); i++) begin
      f = (i == 0 && noise >= 3) || i == cut;
      l = (i == nm.size() - 1) && !(noise >= 8 && noise < 12);
      add_byte(nm[i], f, l, i == scan_at);
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic run_phase(bit hold, bit pause);
    int mid;
    mid = stim_q.size() / 2;
    if (hold) hold_req = 1'b1;
    foreach (stim_q[k]) begin
      if (pause && k == mid) begin
        in_if.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
      end
      send_item(stim_q[k]);
    end
    in_if.valid <= 1'b0;
    stim_q.delete();
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    #2400000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int sent, guard, len, lim;
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_PAT_WORD0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    send_idle_pct = 15;
    recv_idle_pct = 59;
    pat_len_set = 0;
    foreach (pat_bytes[i]) pat_bytes[i] = pick_pat_byte();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset pattern is empty: only the empty name matches
    add_empty(1'b0);
    add_text("a", 1'b0);
    run_phase(1'b0, 1'b0);

    // limit zero refuses all; a dotted name is hidden by a plain star
    pat_bytes[0] = CH_STAR;
    apply_config(1, 0);
    add_text(".x", 1'b0);
    add_empty(1'b0);
    run_phase(1'b0, 1'b0);

    // dotted pattern, zero byte literal, limit above the cap
    pat_bytes[0] = CH_DOT;
    pat_bytes[1] = CH_ANY;
    pat_bytes[2] = 8'h00;
    pat_bytes[3] = CH_STAR;
    apply_config(4, 63);
    add_text(".a_", 1'b0);
    stim_q[$].name_byte = 8'h00;
    add_text(".z_", 1'b0);
    stim_q[$].name_byte = 8'h00;
    stim_q[$-2].first_byte = 1'b0;
    run_phase(1'b0, 1'b0);

    // length above the maximum, long star run, mid-name scan clear, cap hit
    pat_bytes[0] = "a";
    for (int i = 1; i < PATTERN_MAX; i++) pat_bytes[i] = CH_STAR;
    apply_config(40, 2);
    add_text("a", 1'b0);
    add_text("ab", 1'b0);
    stim_q[$].name_byte = 8'hFF;
    stim_q[$].new_scan = 1'b1;
    add_text("ba", 1'b0);
    add_text("aq", 1'b0);
    add_text("ax", 1'b0);
    run_phase(1'b0, 1'b0);

    sent = 0;
    for (int p = 0; sent < 1450; p++) begin
      if (sent < 480) begin
        send_idle_pct = 15;
        recv_idle_pct = 59;
      end else if (sent < 960) begin
        send_idle_pct = 59;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      foreach (pat_bytes[i]) pat_bytes[i] = pick_pat_byte();
      case ($urandom_range(9))
        0:       len = 0;
        1:       len = $urandom_range(32, 63);
        default: len = $urandom_range(1, 10);
      endcase
      case ($urandom_range(5))
        0:       lim = 0;
        1:       lim = 1;
        2:       lim = $urandom_range(32, 63);
        default: lim = $urandom_range(2, 8);
      endcase
      if (p == 0) begin
        len = 32;
        lim = 32;
      end else if (p == 1) begin
        len = 63;
        lim = 63;
      end else if (p == 2) begin
        len = 0;
        lim = 0;
      end
      apply_config(len, lim);
      do add_random_name();
      while (stim_q.size() < 45 || !(stim_q[$].last_byte || stim_q[$].empty_name));
      sent += stim_q.size();
      run_phase(p % 6 == 2, p % 6 == 4);
    end

    guard = 0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    if (sb.pending() != 0) sb.report("verdicts never seen", sb.pending(), 0);
    repeat (8) @(negedge clk);
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
